[hw/rtl/tsra_pkg.sv]
// Shared types, constants and helper functions for the three-axis sample ring average.
package tsra_pkg;

  localparam int DEPTH_LOG2 = 5;
  localparam int DEPTH      = 2 ** DEPTH_LOG2;
  localparam int IDX_W      = DEPTH_LOG2;
  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = SAMPLE_W + DEPTH_LOG2;
  localparam int INDEX_W    = 5;

  typedef enum logic {
    KIND_PUSH  = 1'b0,
    KIND_CLEAR = 1'b1
  } kind_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    logic signed [SAMPLE_W-1:0] z;
  } triple_t;

  typedef struct packed {
    kind_t                      kind;
    logic signed [SAMPLE_W-1:0] sample_x;
    logic signed [SAMPLE_W-1:0] sample_y;
    logic signed [SAMPLE_W-1:0] sample_z;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] last_x;
    logic signed [SAMPLE_W-1:0] last_y;
    logic signed [SAMPLE_W-1:0] last_z;
    logic signed [SAMPLE_W-1:0] mean_x;
    logic signed [SAMPLE_W-1:0] mean_y;
    logic signed [SAMPLE_W-1:0] mean_z;
    logic [INDEX_W-1:0]         write_index;
    logic                       wrapped;
  } out_t;

  function automatic logic [SUM_W-1:0] sext_sum(input logic [SAMPLE_W-1:0] v);
    return {{DEPTH_LOG2{v[SAMPLE_W-1]}}, v};
  endfunction

  // Division by DEPTH rounding toward zero: bias negative sums before the shift.
  function automatic logic [SAMPLE_W-1:0] mean_of(input logic [SUM_W-1:0] sum);
    logic signed [SUM_W-1:0] adj;
    logic signed [SUM_W-1:0] shifted;
    adj     = $signed(sum + (sum[SUM_W-1] ? SUM_W'(DEPTH - 1) : SUM_W'(0)));
    shifted = adj >>> DEPTH_LOG2;
    return shifted[SAMPLE_W-1:0];
  endfunction

endpackage

[hw/rtl/tsra_store.sv]
// Sample store: single-port-read, single-port-write memory with per-entry valid bits.
module tsra_store
  import tsra_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  triple_t          wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output triple_t          rd_data
);

  triple_t            mem [DEPTH];
  logic [DEPTH-1:0]   vld_r;
  triple_t            rd_q_r;
  logic               rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // An entry never written since reset reads as zero.
  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

[hw/rtl/triaxial_sample_ring_average.sv]
// Top level of the three-axis sample ring with running per-axis means.
//
//   port group | direction | handshake          | payload
//   in_        | input     | in_valid/in_ready   | in_t: kind, sample_x/y/z
//   out_       | output    | out_valid/out_ready | out_t: last, mean, write_index, wrapped
//
// One transaction per cycle is sustained while the output is not stalled. The first stage
// reads the store entry; the second stage updates the sums, writes the entry for a push and
// loads the output register. A clear directly after a push to the final entry is forwarded.
// The store reads as zero after reset through valid bits, so there is no clearing pass.
// A stalled output holds the second stage, which in turn holds off new transactions.
module triaxial_sample_ring_average
  import tsra_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic             in_fire;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wp_r;
  logic [IDX_W-1:0] wp_nxt;
  logic             wrap_nxt;

  logic             s1_valid_r;
  kind_t            s1_kind_r;
  triple_t          s1_sample_r;
  logic [IDX_W-1:0] s1_addr_r;
  logic [IDX_W-1:0] s1_wp_r;
  logic             s1_wrap_r;
  logic             s1_fwd_r;
  triple_t          s1_fwd_data_r;
  logic             s1_adv;
  logic             wr_en;

  triple_t          rd_data;
  triple_t          old;
  logic [SUM_W-1:0] sum_x_r;
  logic [SUM_W-1:0] sum_y_r;
  logic [SUM_W-1:0] sum_z_r;
  logic [SUM_W-1:0] sum_x_nxt;
  logic [SUM_W-1:0] sum_y_nxt;
  logic [SUM_W-1:0] sum_z_nxt;
  triple_t          last;

  logic             out_valid_r;
  out_t             out_data_r;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;
  assign wr_en    = s1_adv && (s1_kind_r == KIND_PUSH);

  always_comb begin
    rd_addr  = wp_r;
    wp_nxt   = wp_r + 1'b1;
    wrap_nxt = 1'b0;
    case (in_data.kind)
      KIND_PUSH: begin
        if (wp_r == IDX_W'(DEPTH - 1)) begin
          wp_nxt   = '0;
          wrap_nxt = 1'b1;
        end
      end
      KIND_CLEAR: begin
        rd_addr = IDX_W'(DEPTH - 1);
        wp_nxt  = '0;
      end
      default: begin
        wp_nxt = wp_r;
      end
    endcase
  end

  tsra_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (s1_sample_r),
    .rd_en   (in_fire),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        wp_r <= wp_nxt;
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r     <= in_data.kind;
      s1_sample_r   <= '{x: in_data.sample_x, y: in_data.sample_y, z: in_data.sample_z};
      s1_addr_r     <= wp_r;
      s1_wp_r       <= wp_nxt;
      s1_wrap_r     <= wrap_nxt;
      s1_fwd_r      <= wr_en && (s1_addr_r == rd_addr);
      s1_fwd_data_r <= s1_sample_r;
    end
  end

  assign old = s1_fwd_r ? s1_fwd_data_r : rd_data;

  always_comb begin
    sum_x_nxt = sum_x_r;
    sum_y_nxt = sum_y_r;
    sum_z_nxt = sum_z_r;
    last      = old;
    if (s1_kind_r == KIND_PUSH) begin
      sum_x_nxt = sum_x_r + sext_sum(s1_sample_r.x) - sext_sum(old.x);
      sum_y_nxt = sum_y_r + sext_sum(s1_sample_r.y) - sext_sum(old.y);
      sum_z_nxt = sum_z_r + sext_sum(s1_sample_r.z) - sext_sum(old.z);
      last      = s1_sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      sum_z_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        sum_x_r     <= sum_x_nxt;
        sum_y_r     <= sum_y_nxt;
        sum_z_r     <= sum_z_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r.last_x      <= last.x;
      out_data_r.last_y      <= last.y;
      out_data_r.last_z      <= last.z;
      out_data_r.mean_x      <= mean_of(sum_x_nxt);
      out_data_r.mean_y      <= mean_of(sum_y_nxt);
      out_data_r.mean_z      <= mean_of(sum_z_nxt);
      out_data_r.write_index <= INDEX_W'(s1_wp_r);
      out_data_r.wrapped     <= s1_wrap_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_wrap_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.wrapped |-> out_data.write_index == '0)
    else $error("wrap flag set with a non-zero write index");

  a_accept_to_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_valid_r)
    else $error("accepted transaction missing from second stage");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while the pipeline is stalled");

  a_clear_resets_pos: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.kind == KIND_CLEAR |=> wp_r == '0)
    else $error("write position not reset by a clear");
`endif

endmodule

[dv/tb_triaxial_sample_ring_average.sv]
// Self-checking testbench for the three-axis sample ring with running per-axis means.
`timescale 1ns / 1ps

module tb_triaxial_sample_ring_average;
  import tsra_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 10;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  triaxial_sample_ring_average dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  triple_t        ring_copy [DEPTH];
  int unsigned    ring_pos;
  longint         axis_sum_x;
  longint         axis_sum_y;
  longint         axis_sum_z;

  out_t           expected_results [$];
  out_t           oldest_result;
  int             send_idle_pct;
  int             recv_idle_pct;
  int             sent_count;
  int             checked_count;
  int             push_count;
  int             clear_count;
  int             wrap_count;
  int             error_count;
  int             stall_run;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic out_t predict_ring_result(input in_t item);
    out_t        res;
    int unsigned last_at;
    res = '0;
    if (item.kind == KIND_PUSH) begin
      axis_sum_x += longint'(item.sample_x) - longint'(ring_copy[ring_pos].x);
      axis_sum_y += longint'(item.sample_y) - longint'(ring_copy[ring_pos].y);
      axis_sum_z += longint'(item.sample_z) - longint'(ring_copy[ring_pos].z);
      ring_copy[ring_pos].x = item.sample_x;
      ring_copy[ring_pos].y = item.sample_y;
      ring_copy[ring_pos].z = item.sample_z;
      ring_pos++;
      push_count++;
      if (ring_pos >= DEPTH) begin
        ring_pos    = 0;
        res.wrapped = 1'b1;
        wrap_count++;
      end
    end else begin
      ring_pos = 0;
      clear_count++;
    end
    last_at         = (ring_pos > 0) ? ring_pos - 1 : DEPTH - 1;
    res.last_x      = ring_copy[last_at].x;
    res.last_y      = ring_copy[last_at].y;
    res.last_z      = ring_copy[last_at].z;
    res.mean_x      = SAMPLE_W'(axis_sum_x / DEPTH);
    res.mean_y      = SAMPLE_W'(axis_sum_y / DEPTH);
    res.mean_z      = SAMPLE_W'(axis_sum_z / DEPTH);
    res.write_index = INDEX_W'(ring_pos);
    return res;
  endfunction

  function automatic in_t push_item(input logic [15:0] x, input logic [15:0] y,
                                    input logic [15:0] z);
    in_t item;
    item.kind     = KIND_PUSH;
    item.sample_x = x;
    item.sample_y = y;
    item.sample_z = z;
    return item;
  endfunction

  function automatic in_t clear_item(input logic [15:0] x, input logic [15:0] y,
                                     input logic [15:0] z);
    in_t item;
    item      = push_item(x, y, z);
    item.kind = KIND_CLEAR;
    return item;
  endfunction

  function automatic logic [15:0] random_sample(input int mode);
    logic [15:0] v;
    case (mode)
      0:       v = 16'h7FFF;
      1:       v = 16'h8000;
      2, 3:    v = $urandom_range(1) ? 16'h7FFF : 16'h8000;
      4:       v = 16'($signed($urandom_range(15)) - 8);
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic note_failure(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("ERROR at %0t ns: %s", $realtime, msg);
    end
  endtask

  task automatic send_item(input in_t item);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_ring_result(item));
    sent_count++;
  endtask

  task automatic test_push_extremes();
    send_item(push_item(16'h7FFF, 16'h8000, 16'h0000));
    send_item(push_item(16'h8000, 16'h7FFF, 16'hFFFF));
    send_item(push_item(16'hFFFF, 16'h0000, 16'h7FFF));
    send_item(push_item(16'h0001, 16'hFFFF, 16'h8000));
    send_item(push_item(16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_item(push_item(16'h8000, 16'h8000, 16'h8000));
    send_item(push_item(16'h5555, 16'hAAAA, 16'h5555));
    send_item(push_item(16'hAAAA, 16'h5555, 16'hAAAA));
  endtask

  task automatic test_clear_handling();
    send_item(clear_item(16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(clear_item(16'h7FFF, 16'h8000, 16'h5555));
    send_item(push_item(16'h1234, 16'hEDCB, 16'h0F0F));
    send_item(clear_item(16'h0000, 16'h0000, 16'h0000));
    send_item(push_item(16'hFFFF, 16'h0001, 16'h8001));
    send_item(push_item(16'h7FFE, 16'h8000, 16'h0000));
    send_item(push_item(16'h0000, 16'h7FFF, 16'hFFFE));
    send_item(clear_item(16'hAAAA, 16'h5555, 16'hAAAA));
    send_item(push_item(16'h8000, 16'h8000, 16'h7FFF));
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int item_count);
    int first;
    int run_len;
    int mode;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    first         = sent_count;
    while (sent_count - first < item_count) begin
      mode    = $urandom_range(9);
      run_len = (mode < 2) ? $urandom_range(32, 48) : $urandom_range(1, 40);
      repeat (run_len) begin
        send_item(push_item(random_sample(mode), random_sample(mode), random_sample(mode)));
      end
      if ($urandom_range(2) == 0) begin
        send_item(clear_item(16'($urandom), 16'($urandom), 16'($urandom)));
      end
    end
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_run <= 0;
    end else begin
      stall_run <= stall_run + 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        note_failure("result transaction arrived with no expectation waiting");
      end else begin
        oldest_result = expected_results.pop_front();
        checked_count++;
        if (out_data.last_x !== oldest_result.last_x ||
            out_data.last_y !== oldest_result.last_y ||
            out_data.last_z !== oldest_result.last_z ||
            out_data.mean_x !== oldest_result.mean_x ||
            out_data.mean_y !== oldest_result.mean_y ||
            out_data.mean_z !== oldest_result.mean_z ||
            out_data.write_index !== oldest_result.write_index ||
            out_data.wrapped !== oldest_result.wrapped) begin
          note_failure($sformatf(
            "result %0d: exp last=(%0d,%0d,%0d) mean=(%0d,%0d,%0d) idx=%0d wrap=%0b",
            checked_count, oldest_result.last_x, oldest_result.last_y,
            oldest_result.last_z, oldest_result.mean_x, oldest_result.mean_y,
            oldest_result.mean_z, oldest_result.write_index, oldest_result.wrapped));
          if (error_count <= MAX_REPORTS) begin
            $display("  got last=(%0d,%0d,%0d) mean=(%0d,%0d,%0d) idx=%0d wrap=%0b",
                     out_data.last_x, out_data.last_y, out_data.last_z, out_data.mean_x,
                     out_data.mean_y, out_data.mean_z, out_data.write_index,
                     out_data.wrapped);
          end
        end
      end
    end
  end

  initial begin
    wait (stall_run >= WATCHDOG_LIMIT);
    $display("Watchdog expired after %0d cycles without a transaction.", WATCHDOG_LIMIT);
    $display("triaxial_sample_ring_average verification failed");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    send_idle_pct = 31;
    recv_idle_pct = 50;
    sent_count    = 0;
    checked_count = 0;
    push_count    = 0;
    clear_count   = 0;
    wrap_count    = 0;
    error_count   = 0;
    ring_pos      = 0;
    axis_sum_x    = 0;
    axis_sum_y    = 0;
    axis_sum_z    = 0;
    foreach (ring_copy[i]) ring_copy[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_push_extremes();
    test_clear_handling();
    test_random_traffic(31, 50, 600);
    test_random_traffic(50, 31, 600);
    test_random_traffic(0, 0, 600);

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      note_failure($sformatf("%0d expected results never arrived", expected_results.size()));
    end

    $display("Checked %0d results from %0d transactions: %0d pushes, %0d clears, %0d wraps.",
             checked_count, sent_count, push_count, clear_count, wrap_count);
    $display("Traffic ran with sender and receiver idling in turn, then back to back; %0d errors.",
             error_count);
    if (error_count == 0) begin
      $display("triaxial_sample_ring_average verification clean");
    end else begin
      $display("triaxial_sample_ring_average verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/tsra_pkg.sv
hw/rtl/tsra_store.sv
hw/rtl/triaxial_sample_ring_average.sv
dv/tb_triaxial_sample_ring_average.sv
